// ===== hw/rtl/bfifo_pkg.sv =====
package bfifo_pkg;

  localparam int DEPTH       = 64;
  localparam int MAX_BLOCK   = 8;
  localparam int NUM_LANES   = MAX_BLOCK;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int LEN_W       = IDX_W + 1;
  localparam int CNT_W       = $clog2(MAX_BLOCK + 1);
  localparam int LANE_SEL_W  = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int BANK_DEPTH  = DEPTH / NUM_LANES;
  localparam int ROW_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int BLOCK_W     = 8 * MAX_BLOCK;
  localparam int MAX_RESULTS = DEPTH - 1;

  typedef logic [7:0] byte_t;
  typedef logic [NUM_LANES-1:0][7:0] lane_bytes_t;

  typedef enum logic [2:0] {
    REQ_PUSH    = 3'd0,
    REQ_POP_ONE = 3'd1,
    REQ_POP_ALL = 3'd2,
    REQ_CLEAR   = 3'd3,
    REQ_STATUS  = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    FS_EMPTY = 2'd0,
    FS_DATA  = 2'd1,
    FS_FULL  = 2'd2
  } fill_state_e;

  // Write command broadcast to all lanes for one contiguous run of bytes.
  typedef struct packed {
    logic             active;
    logic [IDX_W-1:0] base;
    logic [CNT_W-1:0] run_len;
    logic [BLOCK_W-1:0] data;
  } lane_cmd_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v < LEN_W'(2)) r = LEN_W'(2);
    if (v > LEN_W'(DEPTH)) r = LEN_W'(DEPTH);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] fill_of(input logic [IDX_W-1:0] wi,
                                                input logic [IDX_W-1:0] ri,
                                                input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] wrap;
    wrap = len - {1'b0, ri} + {1'b0, wi};
    if (wi >= ri) return wi - ri;
    return wrap[IDX_W-1:0];
  endfunction

  function automatic fill_state_e fill_state_of(input logic [IDX_W-1:0] fill,
                                                input logic [LEN_W-1:0] len);
    fill_state_e fs;
    if (fill == '0) fs = FS_EMPTY;
    else if (({1'b0, fill} + LEN_W'(1)) >= len) fs = FS_FULL;
    else fs = FS_DATA;
    return fs;
  endfunction

  // Advance an index by a run that never passes the ring end.
  function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                               input logic [CNT_W-1:0] step,
                                               input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] sum;
    sum = {1'b0, idx} + LEN_W'(step);
    if (sum >= len) return '0;
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/bfifo_if.sv =====
interface bfifo_req_if import bfifo_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [BLOCK_W-1:0] data_bytes;
  logic [CNT_W-1:0]   byte_count;

  modport source (output valid, output req_type, output data_bytes, output byte_count,
                  input ready);
  modport sink (input valid, input req_type, input data_bytes, input byte_count,
                output ready);
endinterface

interface bfifo_rsp_if import bfifo_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status_code;
  logic [7:0]       data_byte;
  logic             last;
  logic [IDX_W-1:0] fill_count;
  logic [1:0]       fill_state;

  modport source (output valid, output status_code, output data_byte, output last,
                  output fill_count, output fill_state, input ready);
  modport sink (input valid, input status_code, input data_byte, input last,
                input fill_count, input fill_state, output ready);
endinterface

// ===== hw/rtl/bfifo_lane.sv =====
module bfifo_lane import bfifo_pkg::*; (
  input  logic                  clk_i,
  input  logic [LANE_SEL_W-1:0] lane_id_i,
  input  lane_cmd_t             cmd_i,
  input  logic [ROW_W-1:0]      rd_row_i,
  output byte_t                 rd_data_o
);

  // Each lane owns the entries whose index modulo the lane count equals its id.
  logic [LANE_SEL_W-1:0] offset;
  logic [IDX_W-1:0]      addr;
  logic                  we;
  byte_t                 wr_byte;
  byte_t                 bank_q [BANK_DEPTH];
  byte_t                 rd_data_q;

  always_comb begin
    offset  = lane_id_i - cmd_i.base[LANE_SEL_W-1:0];
    addr    = cmd_i.base + IDX_W'(offset);
    we      = cmd_i.active && (CNT_W'(offset) < cmd_i.run_len);
    wr_byte = cmd_i.data[{offset, 3'b000} +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      bank_q[addr[IDX_W-1:LANE_SEL_W]] <= wr_byte;
    end
    rd_data_q <= bank_q[rd_row_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/bfifo_merge.sv =====
module bfifo_merge import bfifo_pkg::*; (
  input  logic                  clk_i,
  input  lane_bytes_t           lane_data_i,
  input  logic [LANE_SEL_W-1:0] sel_i,
  output byte_t                 data_o
);

  // The lane select is registered alongside the lanes' read data.
  logic [LANE_SEL_W-1:0] sel_q;

  always_ff @(posedge clk_i) begin
    sel_q <= sel_i;
  end

  assign data_o = lane_data_i[sel_q];

endmodule

// ===== hw/rtl/byte_ring_fifo.sv =====
// Byte ring FIFO. The ring spans the first ring_length bytes of a 64-byte
// store and keeps one slot free, so it holds at most ring_length - 1 bytes.
// A push word carries up to eight bytes and is taken whole or refused with
// status full; pop one returns one byte, pop all returns every stored byte
// oldest first with last set on the final word, clear empties the ring, and
// any other request type is a status query. Every response word reports the
// fill count and fill state after it. Writing ring_length (clamped to 2..64)
// also empties the ring; write it only while the block is idle. Timing: a
// request is taken only when the block is idle and the response register is
// free. Push, clear and status give their response in the cycle after the
// request; a push whose block runs past the ring end writes its two
// contiguous runs in turn, the second in state S_PUSH2, because the eight bank
// lanes can each take one byte per cycle. A pop first enters S_READ while the
// bank lanes and the merge select register the first byte, and then delivers
// one byte per cycle while the response side accepts them.
module byte_ring_fifo import bfifo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  bfifo_req_if.sink        req_i,
  bfifo_rsp_if.source      rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PUSH2 = 3'b010,
    S_READ  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q;
  logic [IDX_W-1:0]   wi_q, wi_d;
  logic [IDX_W-1:0]   ri_q, ri_d;
  logic [BLOCK_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   run2_q, run2_d;
  logic               pop_one_q, pop_one_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;

  logic               rsp_valid_q, rsp_valid_d;
  status_e            rsp_status_q, rsp_status_d;
  byte_t              rsp_data_q, rsp_data_d;
  logic               rsp_last_q, rsp_last_d;
  logic [IDX_W-1:0]   rsp_fill_q, rsp_fill_d;
  fill_state_e        rsp_fs_q, rsp_fs_d;

  logic               can_emit;
  logic               req_ready;
  logic               accept;
  logic               emit;
  logic [CNT_W-1:0]   count_c;
  logic [IDX_W-1:0]   fill_now;
  logic [LEN_W-1:0]   space;
  logic [LEN_W-1:0]   room;
  logic [CNT_W-1:0]   n1;
  logic               push_fit;
  logic [IDX_W-1:0]   ri_next;
  logic               pop_done;
  lane_cmd_t          lane_cmd;
  lane_bytes_t        lane_data;
  byte_t              merged_byte;

  // The bank lanes each hold every eighth byte of the ring. A contiguous run
  // of up to eight bytes therefore touches each lane at most once.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bfifo_lane u_lane (
      .clk_i     (clk_i),
      .lane_id_i (LANE_SEL_W'(g)),
      .cmd_i     (lane_cmd),
      .rd_row_i  (ri_d[IDX_W-1:LANE_SEL_W]),
      .rd_data_o (lane_data[g])
    );
  end

  // The lanes read at the next read index, so the byte at the current read
  // index is always waiting at the merge output.
  bfifo_merge u_merge (
    .clk_i       (clk_i),
    .lane_data_i (lane_data),
    .sel_i       (ri_d[LANE_SEL_W-1:0]),
    .data_o      (merged_byte)
  );

  always_comb begin
    can_emit  = !rsp_valid_q || rsp_o.ready;
    req_ready = (state_q == S_IDLE) && can_emit;
    accept    = req_i.valid && req_ready;

    // A count above the block size is taken as the block size.
    count_c  = (req_i.byte_count > CNT_W'(MAX_BLOCK)) ? CNT_W'(MAX_BLOCK)
                                                      : req_i.byte_count;
    fill_now = fill_of(wi_q, ri_q, len_q);
    space    = len_q - LEN_W'(1) - {1'b0, fill_now};
    push_fit = LEN_W'(count_c) <= space;
    // The first run stops at the ring end; the rest wraps to index zero.
    room     = len_q - {1'b0, wi_q};
    n1       = (LEN_W'(count_c) < room) ? count_c : room[CNT_W-1:0];

    ri_next  = advance(ri_q, CNT_W'(1), len_q);
    pop_done = pop_one_q || (wi_q == ri_next) || (cnt_q == IDX_W'(MAX_RESULTS - 1));

    state_d   = state_q;
    wi_d      = wi_q;
    ri_d      = ri_q;
    rem_d     = rem_q;
    run2_d    = run2_q;
    pop_one_d = pop_one_q;
    cnt_d     = cnt_q;

    lane_cmd.active  = 1'b0;
    lane_cmd.base    = wi_q;
    lane_cmd.run_len = n1;
    lane_cmd.data    = req_i.data_bytes;

    emit         = 1'b0;
    rsp_status_d = ST_OK;
    rsp_data_d   = '0;
    rsp_last_d   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_PUSH: begin
              if (!push_fit) begin
                emit         = 1'b1;
                rsp_status_d = ST_FULL;
              end else begin
                lane_cmd.active = 1'b1;
                wi_d            = advance(wi_q, n1, len_q);
                if (n1 != count_c) begin
                  state_d = S_PUSH2;
                  run2_d  = count_c - n1;
                  rem_d   = req_i.data_bytes >> {n1, 3'b000};
                end else begin
                  emit = 1'b1;
                end
              end
            end
            REQ_POP_ONE, REQ_POP_ALL: begin
              if (wi_q == ri_q) begin
                emit         = 1'b1;
                rsp_status_d = ST_EMPTY;
              end else begin
                state_d   = S_READ;
                pop_one_d = (req_i.req_type == REQ_POP_ONE);
                cnt_d     = '0;
              end
            end
            REQ_CLEAR: begin
              wi_d = '0;
              ri_d = '0;
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_PUSH2: begin
        if (can_emit) begin
          lane_cmd.active  = 1'b1;
          lane_cmd.run_len = run2_q;
          lane_cmd.data    = rem_q;
          wi_d             = advance(wi_q, run2_q, len_q);
          emit             = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_READ: begin
        if (can_emit) begin
          ri_d       = ri_next;
          emit       = 1'b1;
          rsp_data_d = merged_byte;
          rsp_last_d = pop_done;
          cnt_d      = cnt_q + IDX_W'(1);
          if (pop_done) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A length write restarts the ring.
    if (cfg_we_i) begin
      wi_d = '0;
      ri_d = '0;
    end

    rsp_fill_d  = fill_of(wi_d, ri_d, len_q);
    rsp_fs_d    = fill_state_of(rsp_fill_d, len_q);
    rsp_valid_d = emit ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LEN_W'(DEPTH);
      wi_q        <= '0;
      ri_q        <= '0;
      run2_q      <= '0;
      pop_one_q   <= 1'b0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wi_q        <= wi_d;
      ri_q        <= ri_d;
      run2_q      <= run2_d;
      pop_one_q   <= pop_one_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        len_q <= clamp_len(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (emit) begin
      rsp_status_q <= rsp_status_d;
      rsp_data_q   <= rsp_data_d;
      rsp_last_q   <= rsp_last_d;
      rsp_fill_q   <= rsp_fill_d;
      rsp_fs_q     <= rsp_fs_d;
    end
  end

  assign req_i.ready       = req_ready;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status_code = rsp_status_q;
  assign rsp_o.data_byte   = rsp_data_q;
  assign rsp_o.last        = rsp_last_q;
  assign rsp_o.fill_count  = rsp_fill_q;
  assign rsp_o.fill_state  = rsp_fs_q;

`ifndef ASSERT_OFF
  // Both indices stay inside the ring.
  a_idx_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, wi_q} < len_q) && ({1'b0, ri_q} < len_q))
    else $error("ring index outside ring length");

  // A pop only streams while bytes remain.
  a_read_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (wi_q != ri_q))
    else $error("pop streaming from an empty ring");

  // The second run of a wrapped push always starts at index zero.
  a_push2_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH2) |-> (wi_q == '0) && (run2_q != '0))
    else $error("wrapped push second run misplaced");
`endif

endmodule

// ===== dv/byte_fifo_checker.sv =====
// Watches the request and response channels of the byte ring FIFO, keeps a
// shadow copy of the ring and predicts every response word, then compares
// the words that come out against that prediction in order.
module byte_fifo_checker import bfifo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  bfifo_req_if             req_i,
  bfifo_rsp_if             rsp_i,
  output int               mismatches_o,
  output int               words_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e          status;
    byte_t            data;
    logic             last;
    logic [IDX_W-1:0] fill;
    fill_state_e      state;
  } rsp_word_t;

  byte_t            shadow_ring [DEPTH];
  logic [IDX_W-1:0] head_ptr;
  logic [IDX_W-1:0] tail_ptr;
  logic [LEN_W-1:0] ring_len_q;
  rsp_word_t        expected_words [$];
  int               mismatch_cnt;

  function automatic int active_len();
    int len;
    len = ring_len_q;
    if (len < 2) len = 2;
    if (len > DEPTH) len = DEPTH;
    return len;
  endfunction

  function automatic int bytes_stored();
    if (head_ptr >= tail_ptr) return int'(head_ptr) - int'(tail_ptr);
    return active_len() - int'(tail_ptr) + int'(head_ptr);
  endfunction

  function automatic logic [IDX_W-1:0] step_ptr(input logic [IDX_W-1:0] p);
    if (int'(p) + 1 >= active_len()) return '0;
    return p + 1'b1;
  endfunction

  // Builds a response word from the ring occupancy as it stands now.
  function automatic rsp_word_t make_word(input status_e st, input byte_t d, input logic lst);
    rsp_word_t w;
    int fill;
    fill = bytes_stored();
    w.status = st;
    w.data   = d;
    w.last   = lst;
    w.fill   = fill[IDX_W-1:0];
    if (fill == 0) w.state = FS_EMPTY;
    else if (fill + 1 >= active_len()) w.state = FS_FULL;
    else w.state = FS_DATA;
    return w;
  endfunction

  task automatic apply_request(input logic [2:0] kind, input logic [BLOCK_W-1:0] bytes,
                               input logic [CNT_W-1:0] count);
    int cnt;
    int popped;
    logic done;
    byte_t d;
    cnt = (count > MAX_BLOCK) ? MAX_BLOCK : count;
    popped = 0;
    if (kind == REQ_PUSH) begin
      if (cnt > active_len() - 1 - bytes_stored()) begin
        expected_words.push_back(make_word(ST_FULL, 8'h00, 1'b1));
      end else begin
        for (int i = 0; i < cnt; i++) begin
          shadow_ring[head_ptr] = bytes[8*i +: 8];
          head_ptr = step_ptr(head_ptr);
        end
        expected_words.push_back(make_word(ST_OK, 8'h00, 1'b1));
      end
    end else if (kind == REQ_POP_ONE || kind == REQ_POP_ALL) begin
      if (head_ptr == tail_ptr) begin
        expected_words.push_back(make_word(ST_EMPTY, 8'h00, 1'b1));
      end else begin
        do begin
          d = shadow_ring[tail_ptr];
          tail_ptr = step_ptr(tail_ptr);
          done = (kind == REQ_POP_ONE) || (head_ptr == tail_ptr) || (popped + 1 >= DEPTH - 1);
          expected_words.push_back(make_word(ST_OK, d, done));
          popped++;
        end while (!done);
      end
    end else begin
      if (kind == REQ_CLEAR) begin
        head_ptr = '0;
        tail_ptr = '0;
      end
      expected_words.push_back(make_word(ST_OK, 8'h00, 1'b1));
    end
  endtask

  task automatic check_word();
    rsp_word_t want;
    rsp_word_t got;
    got.status = status_e'(rsp_i.status_code);
    got.data   = rsp_i.data_byte;
    got.last   = rsp_i.last;
    got.fill   = rsp_i.fill_count;
    got.state  = fill_state_e'(rsp_i.fill_state);
    if (expected_words.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%t: unexpected word st=%0d data=%02h last=%0b fill=%0d fs=%0d", $realtime,
                 got.status, got.data, got.last, got.fill, got.state);
    end else begin
      want = expected_words.pop_front();
      if (got !== want) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%t: word mismatch exp st=%0d data=%02h last=%0b fill=%0d fs=%0d, got st=%0d data=%02h last=%0b fill=%0d fs=%0d",
                   $realtime, want.status, want.data, want.last, want.fill, want.state,
                   got.status, got.data, got.last, got.fill, got.state);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr = '0;
      tail_ptr = '0;
      ring_len_q = LEN_W'(DEPTH);
      expected_words.delete();
      mismatch_cnt = 0;
      mismatches_o <= 0;
      words_pending_o <= 0;
    end else begin
      // A length write empties the ring.
      if (cfg_we_i) begin
        ring_len_q = cfg_wdata_i;
        head_ptr = '0;
        tail_ptr = '0;
      end
      if (rsp_i.valid && rsp_i.ready) check_word();
      if (req_i.valid && req_i.ready)
        apply_request(req_i.req_type, req_i.data_bytes, req_i.byte_count);
      mismatches_o <= mismatch_cnt;
      words_pending_o <= expected_words.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the byte ring FIFO bench. This module only makes stimulus and gives
// the verdict; the checker instance beside the block predicts and compares.
module testbench import bfifo_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Request types 5 to 7 are unused codes that the block treats as a status query.
  localparam logic [2:0] REQ_RSVD_FIRST = 3'd5;
  localparam logic [2:0] REQ_RSVD_LAST  = 3'd7;
  localparam int PHASE_WORDS = 56;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_PCT    = 35;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;
  int               mismatches;
  int               words_pending;

  // Knobs for the two sides. The receiver process reads them on each edge.
  bit tx_gaps;
  bit rx_random;
  bit rx_hold_req;

  bfifo_req_if req_bus ();
  bfifo_rsp_if rsp_bus ();

  byte_ring_fifo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  byte_fifo_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_i           (req_bus),
    .rsp_i           (rsp_bus),
    .mismatches_o    (mismatches),
    .words_pending_o (words_pending)
  );

  always #1 clk_i = ~clk_i;

  // Offers one request word and returns at the edge where it is taken. The
  // valid line is lowered only when a gap is inserted, so back-to-back words
  // never see valid dropped and raised again within one time step.
  task automatic send_req(input logic [2:0] kind, input logic [BLOCK_W-1:0] bytes,
                          input logic [CNT_W-1:0] count);
    int gap;
    gap = 0;
    if (tx_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.data_bytes <= bytes;
    req_bus.byte_count <= count;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Stops offering, waits until every predicted word has come out, and then
  // lets the block run on so that it is fully idle.
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called while the block is idle; the write also empties the ring.
  task automatic write_ring_length(input logic [LEN_W-1:0] len);
    cfg_wdata_i <= len;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // One random request word. Pushes dominate when push_pct is high, which
  // walks the ring up to full and keeps it wrapping; the rest are pops and
  // the occasional clear, status query or unused request type.
  task automatic send_random(input int push_pct);
    int pick;
    logic [CNT_W-1:0] count;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 85) count = CNT_W'($urandom_range(MAX_BLOCK));
    else count = CNT_W'($urandom_range(15, MAX_BLOCK + 1));
    if (pick < push_pct) begin
      send_req(REQ_PUSH, {$urandom, $urandom}, count);
    end else begin
      pick = $urandom_range(99);
      if (pick < 40) send_req(REQ_POP_ONE, {$urandom, $urandom}, count);
      else if (pick < 65) send_req(REQ_POP_ALL, {$urandom, $urandom}, count);
      else if (pick < 80) send_req(REQ_STATUS, {$urandom, $urandom}, count);
      else if (pick < 90)
        send_req(3'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST)), {$urandom, $urandom}, count);
      else send_req(REQ_CLEAR, {$urandom, $urandom}, count);
    end
  endtask

  // Response side: random stalls, a no-stall mode, and one long hold-off on
  // request. During the hold-off the response register stays occupied, so
  // the block has to stop taking requests while the sender keeps offering.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_random) begin
        rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [LEN_W-1:0] phase_len [8];
    phase_len = '{7'd2, 7'd64, 7'd0, 7'd9, 7'd127, 7'd1, 7'd0, 7'd17};
    phase_len[6] = LEN_W'($urandom_range(DEPTH - 1, 3));

    // Every input is at a known value before the first edge.
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = LEN_W'(DEPTH);
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_STATUS;
    req_bus.data_bytes = '0;
    req_bus.byte_count = '0;
    tx_gaps            = 1'b1;
    rx_random          = 1'b1;
    rx_hold_req        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset length of 64, so 63 bytes fit.
    // Status, pop one and pop all on an empty ring, then an empty push.
    send_req(REQ_STATUS, '0, '0);
    send_req(REQ_POP_ONE, '1, '1);
    send_req(REQ_POP_ALL, '0, '0);
    send_req(REQ_PUSH, '1, '0);
    // All-ones block, then an oversized count that acts as eight bytes.
    send_req(REQ_PUSH, '1, CNT_W'(MAX_BLOCK));
    send_req(REQ_PUSH, '0, '1);
    send_req(REQ_POP_ONE, '0, '0);
    send_req(REQ_POP_ALL, '1, '1);
    // Fill with seven blocks of eight, see a block refused as full, top the
    // ring off to exactly full, and see a single extra byte refused.
    for (int i = 0; i < 7; i++) begin
      send_req(REQ_PUSH, {$urandom, $urandom}, CNT_W'(MAX_BLOCK));
    end
    send_req(REQ_PUSH, {$urandom, $urandom}, CNT_W'(MAX_BLOCK));
    send_req(REQ_PUSH, {$urandom, $urandom}, CNT_W'(MAX_BLOCK - 1));
    send_req(REQ_PUSH, {$urandom, $urandom}, 4'd1);
    // Unused request types behave as a status query on a full ring.
    send_req(REQ_RSVD_FIRST, '1, '1);
    send_req(REQ_RSVD_LAST, '0, '0);
    // Pop all drains the full ring: 63 words with last on the final one.
    send_req(REQ_POP_ALL, '0, '0);
    send_req(REQ_PUSH, {$urandom, $urandom}, 4'd3);
    send_req(REQ_CLEAR, '1, '1);
    send_req(REQ_POP_ONE, '0, '0);

    // Random phases, each at its own ring length; the extremes and the
    // out-of-range lengths that clamp to 2 and 64 are among them. Phase 1
    // carries the long receiver hold-off, phase 3 has no idling at all.
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      tx_gaps   = (phase != 3);
      rx_random = (phase != 3);
      write_ring_length(phase_len[phase]);
      if (phase == 1) rx_hold_req = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_random((phase % 2 == 1) ? 70 : 50);
      end
    end

    drain();
    if (mismatches == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bfifo_pkg.sv
hw/rtl/bfifo_if.sv
hw/rtl/bfifo_lane.sv
hw/rtl/bfifo_merge.sv
hw/rtl/byte_ring_fifo.sv
dv/byte_fifo_checker.sv
dv/testbench.sv
